// File: hw/rtl/eab_pkg.sv
`default_nettype none
package eab_pkg;
    localparam int WORK_FRAC = 30;
    localparam int XW = 34;
    localparam int ZW = 34;
    localparam int FIELD_W = 16;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef logic signed [XW-1:0] xy_t;
    typedef logic signed [ZW-1:0] zang_t;

    typedef struct packed {
        xy_t   x;
        xy_t   y;
        zang_t z;
        logic  flip;
    } rot_t;

    function automatic zang_t atan_at(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return zang_t'({2'b00, t});
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/eab_cell.sv
`default_nettype none
module eab_cell #(
    parameter int STAGE = 0
) (
    input  wire logic           clk,
    input  wire eab_pkg::rot_t  a_in,
    input  wire eab_pkg::rot_t  b_in,
    input  wire eab_pkg::rot_t  c_in,
    output eab_pkg::rot_t       a_out,
    output eab_pkg::rot_t       b_out,
    output eab_pkg::rot_t       c_out
);
    function automatic eab_pkg::rot_t step(input eab_pkg::rot_t r);
        eab_pkg::rot_t o;
        eab_pkg::xy_t dx;
        eab_pkg::xy_t dy;
        dx = r.y >>> STAGE;
        dy = r.x >>> STAGE;
        o = r;
        if (!r.z[eab_pkg::ZW-1])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - eab_pkg::atan_at(STAGE);
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + eab_pkg::atan_at(STAGE);
        end
        return o;
    endfunction

    eab_pkg::rot_t a_reg, b_reg, c_reg;
    always_ff @(posedge clk)
    begin
        a_reg <= step(a_in);
        b_reg <= step(b_in);
        c_reg <= step(c_in);
    end
    assign a_out = a_reg;
    assign b_out = b_reg;
    assign c_out = c_reg;
endmodule
`default_nettype wire

// File: hw/rtl/eab_mul.sv
`default_nettype none
module eab_mul (
    input  wire logic        clk,
    input  wire eab_pkg::xy_t a,
    input  wire eab_pkg::xy_t b,
    output eab_pkg::xy_t     p
);
    logic signed [2*eab_pkg::XW-1:0] prod;
    eab_pkg::xy_t p_reg;
    always_comb
    begin
        prod = a * b + (68'sd1 <<< (eab_pkg::WORK_FRAC - 1));
    end
    always_ff @(posedge clk)
    begin
        p_reg <= prod[eab_pkg::WORK_FRAC +: eab_pkg::XW];
    end
    assign p = p_reg;
endmodule
`default_nettype wire

// File: hw/rtl/euler_angles_to_basis_vectors.sv
`default_nettype none
// euler angles to forward/right/up basis vectors
// command channel: pitch_angle, yaw_angle, roll_angle are taken at a clock edge
// where start is high and busy is low; busy is always low, so one item can be
// issued every cycle
// result channel: the nine Q1.OUT_FRAC_BITS components appear together for one
// cycle with done high; the receiver cannot stall and must take them then
// latency: CORDIC_STAGES + 4 cycles from accept to done (one fold stage, a
// cordic cell per stage, two product stages, one output stage)
// throughput: one item per cycle, set by the chain of cordic cells and the
// pipelined multipliers
// reset clears the valid chain only; no item is lost or invented after reset
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] pitch_angle,
    input  wire logic [15:0] yaw_angle,
    input  wire logic [15:0] roll_angle,
    output logic             done,
    output logic signed [15:0] forward_x,
    output logic signed [15:0] forward_y,
    output logic signed [15:0] forward_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);
    localparam int LAT = CORDIC_STAGES + 4;
    localparam int SH = eab_pkg::WORK_FRAC - OUT_FRAC_BITS;

    function automatic eab_pkg::rot_t fold(input logic [15:0] raw);
        eab_pkg::rot_t r;
        logic [31:0] turn;
        logic flip;
        turn = 32'(raw) << (32 - ANGLE_BITS);
        flip = turn[31] ^ turn[30];
        if (flip)
        begin
            turn = turn + 32'h80000000;
        end
        r.x = eab_pkg::CORDIC_GAIN;
        r.y = '0;
        r.z = eab_pkg::zang_t'(signed'(turn));
        r.flip = flip;
        return r;
    endfunction

    function automatic eab_pkg::xy_t unfold_s(input eab_pkg::rot_t r);
        return r.flip ? -r.y : r.y;
    endfunction
    function automatic eab_pkg::xy_t unfold_c(input eab_pkg::rot_t r);
        return r.flip ? -r.x : r.x;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [eab_pkg::XW+1:0] v);
        logic signed [eab_pkg::XW+1:0] r;
        logic signed [eab_pkg::XW+1:0] lim;
        lim = (eab_pkg::XW+2)'(1) <<< OUT_FRAC_BITS;
        if (SH == 0)
            r = v;
        else
            r = (v + ((eab_pkg::XW+2)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    logic [LAT-1:0] vld_reg;
    assign busy = 1'b0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end
    assign done = vld_reg[LAT-1];

    eab_pkg::rot_t pa [CORDIC_STAGES+1];
    eab_pkg::rot_t ya [CORDIC_STAGES+1];
    eab_pkg::rot_t ra [CORDIC_STAGES+1];

    always_ff @(posedge clk)
    begin
        pa[0] <= fold(pitch_angle);
        ya[0] <= fold(yaw_angle);
        ra[0] <= fold(roll_angle);
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        eab_cell #(.STAGE(g)) u_cell (
            .clk(clk), .a_in(pa[g]), .b_in(ya[g]), .c_in(ra[g]),
            .a_out(pa[g+1]), .b_out(ya[g+1]), .c_out(ra[g+1])
        );
    end

    eab_pkg::xy_t sp, cp, sy, cy, sr, cr;
    assign sp = unfold_s(pa[CORDIC_STAGES]);
    assign cp = unfold_c(pa[CORDIC_STAGES]);
    assign sy = unfold_s(ya[CORDIC_STAGES]);
    assign cy = unfold_c(ya[CORDIC_STAGES]);
    assign sr = unfold_s(ra[CORDIC_STAGES]);
    assign cr = unfold_c(ra[CORDIC_STAGES]);

    eab_pkg::xy_t srsp, crsp, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
    eab_pkg::xy_t sp_d_reg, cy_d_reg, sy_d_reg, sp_dd_reg;
    eab_pkg::xy_t cpcy_reg, cpsy_reg, crsy_reg, crcy_reg, srcp_reg, srsy_reg, srcy_reg, crcp_reg;
    eab_mul u_m0 (.clk(clk), .a(sr), .b(sp), .p(srsp));
    eab_mul u_m1 (.clk(clk), .a(cr), .b(sp), .p(crsp));
    eab_mul u_m2 (.clk(clk), .a(cp), .b(cy), .p(cpcy));
    eab_mul u_m3 (.clk(clk), .a(cp), .b(sy), .p(cpsy));
    eab_mul u_m4 (.clk(clk), .a(cr), .b(sy), .p(crsy));
    eab_mul u_m5 (.clk(clk), .a(cr), .b(cy), .p(crcy));
    eab_mul u_m6 (.clk(clk), .a(sr), .b(cp), .p(srcp));
    eab_mul u_m7 (.clk(clk), .a(sr), .b(sy), .p(srsy));
    eab_mul u_m8 (.clk(clk), .a(sr), .b(cy), .p(srcy));
    eab_mul u_m9 (.clk(clk), .a(cr), .b(cp), .p(crcp));

    always_ff @(posedge clk)
    begin
        sp_d_reg  <= sp;
        cy_d_reg  <= cy;
        sy_d_reg  <= sy;
        sp_dd_reg <= sp_d_reg;
        cpcy_reg <= cpcy; cpsy_reg <= cpsy; crsy_reg <= crsy; crcy_reg <= crcy;
        srcp_reg <= srcp; srsy_reg <= srsy; srcy_reg <= srcy; crcp_reg <= crcp;
    end

    eab_pkg::xy_t t0, t1, t2, t3;
    eab_mul u_m10 (.clk(clk), .a(srsp), .b(cy_d_reg), .p(t0));
    eab_mul u_m11 (.clk(clk), .a(srsp), .b(sy_d_reg), .p(t1));
    eab_mul u_m12 (.clk(clk), .a(crsp), .b(cy_d_reg), .p(t2));
    eab_mul u_m13 (.clk(clk), .a(crsp), .b(sy_d_reg), .p(t3));

    typedef logic signed [eab_pkg::XW+1:0] wide_t;
    always_ff @(posedge clk)
    begin
        forward_x <= to_out(wide_t'(cpcy_reg));
        forward_y <= to_out(wide_t'(cpsy_reg));
        forward_z <= to_out(-wide_t'(sp_dd_reg));
        right_x   <= to_out(wide_t'(crsy_reg) - wide_t'(t0));
        right_y   <= to_out(-wide_t'(t1) - wide_t'(crcy_reg));
        right_z   <= to_out(-wide_t'(srcp_reg));
        up_x      <= to_out(wide_t'(t2) + wide_t'(srsy_reg));
        up_y      <= to_out(wide_t'(t3) - wide_t'(srcy_reg));
        up_z      <= to_out(wide_t'(crcp_reg));
    end
endmodule
`default_nettype wire

// File: hw/rtl/eab_checker.sv
`default_nettype none
module eab_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic signed [15:0] forward_z,
    input wire logic signed [15:0] up_z
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##20 done) else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 20)) else $error("spurious result");
    a_fz_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (forward_z <= 16'sd16384 && forward_z >= -16'sd16384))
        else $error("forward_z out of range");
    a_uz_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (up_z <= 16'sd16384 && up_z >= -16'sd16384))
        else $error("up_z out of range");
endmodule

bind euler_angles_to_basis_vectors eab_checker u_eab_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .forward_z(forward_z), .up_z(up_z)
);
`default_nettype wire

// File: bench/euler_angles_to_basis_vectors_tb.sv
`default_nettype none
module euler_angles_to_basis_vectors_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 4;
    localparam int N_RANDOM = 1750;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
    } angles_t;

    typedef struct packed {
        logic [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    } basis_t;

    typedef struct packed {
        angles_t a;
        logic    known;
        basis_t  b;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [15:0] pitch_angle = '0, yaw_angle = '0, roll_angle = '0;
    wire busy, done;
    wire signed [15:0] forward_x, forward_y, forward_z, right_x, right_y, right_z;
    wire signed [15:0] up_x, up_y, up_z;

    basis_t expected_basis[$];
    int mismatches = 0;
    int cycles = 0;

    euler_angles_to_basis_vectors dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .done(done),
        .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z)
    );

    always #5 clk = ~clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_step(int i);
        longint t [0:15] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        return t[i];
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang, output longint s,
                                        output longint c);
        logic [31:0] turn;
        logic flip;
        longint x, y, z, dx, dy;
        turn = {ang, 16'h0};
        flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
        x = 64'h26DD3B6A;
        y = 0;
        if (flip)
            turn = turn + 32'h80000000;
        z = longint'(signed'(turn));
        for (int i = 0; i < STAGES; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return shr_floor(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        longint r;
        r = shr_floor(v + (64'sd1 <<< 15), 16);
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic basis_t basis_of(angles_t a);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        basis_t b;
        sine_cosine(a.pitch, sp, cp);
        sine_cosine(a.yaw, sy, cy);
        sine_cosine(a.roll, sr, cr);
        srsp = q30_mul(sr, sp);
        crsp = q30_mul(cr, sp);
        b.fx = to_q14(q30_mul(cp, cy));
        b.fy = to_q14(q30_mul(cp, sy));
        b.fz = to_q14(-sp);
        b.rx = to_q14(q30_mul(cr, sy) - q30_mul(srsp, cy));
        b.ry = to_q14(-q30_mul(srsp, sy) - q30_mul(cr, cy));
        b.rz = to_q14(-q30_mul(sr, cp));
        b.ux = to_q14(q30_mul(crsp, cy) + q30_mul(sr, sy));
        b.uy = to_q14(q30_mul(crsp, sy) - q30_mul(sr, cy));
        b.uz = to_q14(q30_mul(cr, cp));
        return b;
    endfunction

    // all angles zero gives identity-like axes, handy to type in
    localparam basis_t ZERO_BASIS = '{fx: 16'sd16384, fy: 16'sd0, fz: 16'sd0,
        rx: 16'sd0, ry: -16'sd16384, rz: 16'sd0, ux: 16'sd0, uy: 16'sd0, uz: 16'sd16384};

    row_t directed[] = '{
        '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, ZERO_BASIS},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{16'h4000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{16'h8000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{16'hC000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{16'h0000, 16'h4000, 16'h0000}, 1'b0, '0},
        '{'{16'h0000, 16'h8000, 16'h0000}, 1'b0, '0},
        '{'{16'h0000, 16'hC000, 16'h0000}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 16'h4000}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 16'h8000}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 16'hC000}, 1'b0, '0},
        '{'{16'h3FFF, 16'h7FFF, 16'hBFFF}, 1'b0, '0},
        '{'{16'h4001, 16'h8001, 16'hC001}, 1'b0, '0},
        '{'{16'h2000, 16'h2000, 16'h2000}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{'{16'h0001, 16'h7FFF, 16'h8000}, 1'b0, '0},
        '{'{16'hE000, 16'h6000, 16'hA000}, 1'b0, '0}
    };

    task automatic issue_item(input angles_t a, input basis_t b);
        start <= 1'b1;
        pitch_angle <= a.pitch;
        yaw_angle <= a.yaw;
        roll_angle <= a.roll;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_basis.push_back(b);
        @(negedge clk);
    endtask

    task automatic idle_burst(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_basis.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected item at cycle %0d", cycles);
            end
            else
            begin
                basis_t e, g;
                e = expected_basis.pop_front();
                g = '{forward_x, forward_y, forward_z, right_x, right_y, right_z,
                      up_x, up_y, up_z};
                if (g !== e)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d exp %h got %h", cycles, e, g);
                end
            end
        end
    end

    initial
    begin
        angles_t a;
        basis_t b;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
        begin
            b = directed[i].known ? directed[i].b : basis_of(directed[i].a);
            issue_item(directed[i].a, b);
        end
        start <= 1'b0;
        while (expected_basis.size() != 0)
            @(negedge clk);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            a.pitch = 16'($urandom_range(0, 65535));
            a.yaw = 16'($urandom_range(0, 65535));
            a.roll = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 7) == 0)
                a.pitch = {2'($urandom_range(0, 3)), 14'h0};
            if (n == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (expected_basis.size() != 0)
                    @(negedge clk);
            end
            if (n < N_RANDOM * 3 / 4 && (n % 200) >= 100 && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 7));
            issue_item(a, basis_of(a));
        end
        start <= 1'b0;
        while (expected_basis.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (mismatches == 0 && expected_basis.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
